// ----- rtl/motion_move_statistics_unit_assert.svh -----
// Assertion macros for the motion move statistics checker.
// Assumes i_clk and i_rst_n are visible where the macros are used.
`ifndef MOTION_MOVE_STATISTICS_UNIT_ASSERT_SVH
`define MOTION_MOVE_STATISTICS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("msu check failed");

// Next-cycle implication.
`define MSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("msu check failed");

`endif

// ----- rtl/msu_pkg.sv -----
// Shared widths, limits and types for the motion move statistics unit.
// No dependencies.
package msu_pkg;

    localparam int ANGLE_BITS = 12;
    localparam int ANGLE_IN_W = 12;
    localparam int SPEED_IN_W = 21;
    localparam int PWM_IN_W   = 8;
    localparam int TIME_W     = 32;
    localparam int TRAVEL_W   = 40;
    localparam int SPEED_W    = 20;
    localparam int PWM_W      = 7;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 32;
    localparam int BIT_W      = $clog2(SUM_W);

    localparam int SPEED_CLAMP = 1000000;
    localparam int PWM_CLAMP   = 100;

    typedef logic [ANGLE_BITS-1:0] t_angle;

    typedef struct packed {
        logic done;
        logic zero_div;
    } t_div_stat;

endpackage

// ----- rtl/motion_move_statistics_unit.sv -----
// Motion move statistics: per-move travel, speed and PWM summary from status samples.
// Depends on msu_pkg and msu_serial_div.
//
// One status sample is taken per request. An idle or paused sample that changes
// nothing leaves the unit idle. During a move, each sample passes through the
// accumulate state: the travel, speed-sum and sample-count accumulators sit in
// shift registers and are added one bit per cycle over the 48-bit sum width. A
// sample that ends a move passes through the bit-serial divider that forms the
// mean speed (one quotient bit per cycle over 48 bits), then waits while the
// previous summary still waits in the output register. One summary is held in
// the output register while the next samples are taken.
module motion_move_statistics_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_move_active,
    input  logic                             i_paused_for_sensor,
    input  logic                             i_sensor_valid,
    input  logic [msu_pkg::ANGLE_IN_W-1:0]   i_angle_counts,
    input  logic signed [msu_pkg::SPEED_IN_W-1:0] i_speed_centi_rpm,
    input  logic signed [msu_pkg::PWM_IN_W-1:0]   i_pwm_percent,
    input  logic [msu_pkg::TIME_W-1:0]       i_time_ms,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [msu_pkg::TIME_W-1:0]       o_elapsed_ms,
    output logic [msu_pkg::TRAVEL_W-1:0]     o_travel_counts,
    output logic [msu_pkg::SPEED_W-1:0]      o_peak_speed,
    output logic [msu_pkg::SPEED_W-1:0]      o_mean_speed,
    output logic [msu_pkg::PWM_W-1:0]        o_peak_pwm
);
    import msu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic                r_moving, n_moving;
    logic                r_last_valid, n_last_valid;
    logic                r_out_valid, n_out_valid;
    t_angle              r_last_angle, n_last_angle;
    logic [TIME_W-1:0]   r_start_time, n_start_time;
    logic [TRAVEL_W-1:0] r_travel, n_travel;
    logic [SPEED_W-1:0]  r_speed_peak, n_speed_peak;
    logic [SUM_W-1:0]    r_ssum, n_ssum;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PWM_W-1:0]    r_pwm_peak, n_pwm_peak;
    logic [BIT_W-1:0]    r_bit, n_bit;
    t_angle              r_add_t, n_add_t;
    logic [SPEED_W-1:0]  r_add_s, n_add_s;
    logic                r_inc, n_inc;
    logic                r_ct, n_ct;
    logic                r_cs, n_cs;
    logic                r_cc, n_cc;
    logic [TIME_W-1:0]   r_dur, n_dur;
    logic [TIME_W-1:0]   r_out_dur, n_out_dur;
    logic [TRAVEL_W-1:0] r_out_travel, n_out_travel;
    logic [SPEED_W-1:0]  r_out_peak, n_out_peak;
    logic [SPEED_W-1:0]  r_out_mean, n_out_mean;
    logic [PWM_W-1:0]    r_out_pwm, n_out_pwm;

    logic                w_take;
    logic                w_start;
    logic                w_div_go;
    t_angle              w_ang;
    t_angle              w_diff;
    t_angle              w_rev;
    t_angle              w_step;
    logic [SPEED_IN_W-1:0] w_spd_raw;
    logic [SPEED_IN_W-1:0] w_spd_abs;
    logic [SPEED_W-1:0]  w_spd;
    logic [PWM_IN_W-1:0] w_pwm_raw;
    logic [PWM_IN_W-1:0] w_pwm_abs;
    logic [PWM_W-1:0]    w_pwm;
    logic [SPEED_W-1:0]  w_speed_base;
    logic [PWM_W-1:0]    w_pwm_base;
    logic                w_t_sum, w_t_cy;
    logic                w_s_add, w_s_sum, w_s_cy;
    t_div_stat           w_div_stat;
    logic [SUM_W-1:0]    w_quo;

    assign o_stall = (r_state != ST_IDLE);
    assign w_take  = i_valid && !o_stall;
    assign w_start = i_move_active && !r_moving;

    assign w_ang  = t_angle'(i_angle_counts);
    assign w_diff = w_ang - r_last_angle;
    assign w_rev  = t_angle'(0) - w_diff;
    assign w_step = (w_diff < w_rev) ? w_diff : w_rev;

    assign w_spd_raw = $unsigned(i_speed_centi_rpm);
    assign w_spd_abs = w_spd_raw[SPEED_IN_W-1] ? (~w_spd_raw + SPEED_IN_W'(1)) : w_spd_raw;
    assign w_spd     = (w_spd_abs > SPEED_IN_W'(SPEED_CLAMP)) ? SPEED_W'(SPEED_CLAMP)
                                                              : w_spd_abs[SPEED_W-1:0];

    assign w_pwm_raw = $unsigned(i_pwm_percent);
    assign w_pwm_abs = w_pwm_raw[PWM_IN_W-1] ? (~w_pwm_raw + PWM_IN_W'(1)) : w_pwm_raw;
    assign w_pwm     = (w_pwm_abs > PWM_IN_W'(PWM_CLAMP)) ? PWM_W'(PWM_CLAMP)
                                                          : w_pwm_abs[PWM_W-1:0];

    assign w_speed_base = w_start ? '0 : r_speed_peak;
    assign w_pwm_base   = w_start ? '0 : r_pwm_peak;

    assign w_t_sum = r_travel[0] ^ r_add_t[0] ^ r_ct;
    assign w_t_cy  = (r_travel[0] & r_add_t[0]) | (r_ct & (r_travel[0] ^ r_add_t[0]));
    assign w_s_add = r_add_s[0] & r_inc;
    assign w_s_sum = r_ssum[0] ^ w_s_add ^ r_cs;
    assign w_s_cy  = (r_ssum[0] & w_s_add) | (r_cs & (r_ssum[0] ^ w_s_add));

    assign w_div_go = w_take && !i_move_active && r_moving && !i_paused_for_sensor;

    msu_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_go),
        .i_dividend (r_ssum),
        .i_divisor  (r_count),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state      = r_state;
        n_moving     = r_moving;
        n_last_valid = r_last_valid;
        n_out_valid  = r_out_valid && i_stall;
        n_last_angle = r_last_angle;
        n_start_time = r_start_time;
        n_travel     = r_travel;
        n_speed_peak = r_speed_peak;
        n_ssum       = r_ssum;
        n_count      = r_count;
        n_pwm_peak   = r_pwm_peak;
        n_bit        = r_bit;
        n_add_t      = r_add_t;
        n_add_s      = r_add_s;
        n_inc        = r_inc;
        n_ct         = r_ct;
        n_cs         = r_cs;
        n_cc         = r_cc;
        n_dur        = r_dur;
        n_out_dur    = r_out_dur;
        n_out_travel = r_out_travel;
        n_out_peak   = r_out_peak;
        n_out_mean   = r_out_mean;
        n_out_pwm    = r_out_pwm;

        case (r_state)
            ST_IDLE: begin
                if (w_take && i_move_active) begin
                    if (w_start) begin
                        n_moving     = 1'b1;
                        n_start_time = i_time_ms;
                        n_travel     = '0;
                        n_ssum       = '0;
                        n_count      = '0;
                    end
                    n_add_t = (i_sensor_valid && r_last_valid && !w_start) ? w_step : '0;
                    if (i_sensor_valid || w_start) begin
                        n_last_angle = w_ang;
                    end
                    n_last_valid = i_sensor_valid || (r_last_valid && !w_start);
                    n_speed_peak = (w_spd > w_speed_base) ? w_spd : w_speed_base;
                    n_pwm_peak   = (w_pwm > w_pwm_base) ? w_pwm : w_pwm_base;
                    n_add_s      = w_spd;
                    n_inc        = w_start || !(&r_count);
                    n_cc         = w_start || !(&r_count);
                    n_ct         = 1'b0;
                    n_cs         = 1'b0;
                    n_bit        = '0;
                    n_state      = ST_ACC;
                end else if (w_div_go) begin
                    n_dur        = i_time_ms - r_start_time;
                    n_moving     = 1'b0;
                    n_last_valid = 1'b0;
                    n_state      = ST_DIV;
                end
            end
            ST_ACC: begin
                if (r_bit < BIT_W'(TRAVEL_W)) begin
                    n_travel = {w_t_sum, r_travel[TRAVEL_W-1:1]};
                    n_ct     = w_t_cy;
                    n_add_t  = r_add_t >> 1;
                end
                if (r_bit < BIT_W'(CNT_W)) begin
                    n_count = {r_count[0] ^ r_cc, r_count[CNT_W-1:1]};
                    n_cc    = r_count[0] & r_cc;
                end
                n_ssum  = {w_s_sum, r_ssum[SUM_W-1:1]};
                n_cs    = w_s_cy;
                n_add_s = r_add_s >> 1;
                n_bit   = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(SUM_W - 1)) begin
                    if (r_ct) begin
                        n_travel = '1;
                    end
                    if (w_s_cy) begin
                        n_ssum = '1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_dur    = r_dur;
                    n_out_travel = r_travel;
                    n_out_peak   = r_speed_peak;
                    n_out_mean   = w_div_stat.zero_div ? '0 : w_quo[SPEED_W-1:0];
                    n_out_pwm    = r_pwm_peak;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_moving     <= 1'b0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_moving     <= n_moving;
            r_last_valid <= n_last_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_angle <= n_last_angle;
        r_start_time <= n_start_time;
        r_travel     <= n_travel;
        r_speed_peak <= n_speed_peak;
        r_ssum       <= n_ssum;
        r_count      <= n_count;
        r_pwm_peak   <= n_pwm_peak;
        r_bit        <= n_bit;
        r_add_t      <= n_add_t;
        r_add_s      <= n_add_s;
        r_inc        <= n_inc;
        r_ct         <= n_ct;
        r_cs         <= n_cs;
        r_cc         <= n_cc;
        r_dur        <= n_dur;
        r_out_dur    <= n_out_dur;
        r_out_travel <= n_out_travel;
        r_out_peak   <= n_out_peak;
        r_out_mean   <= n_out_mean;
        r_out_pwm    <= n_out_pwm;
    end

    assign o_valid         = r_out_valid;
    assign o_elapsed_ms    = r_out_dur;
    assign o_travel_counts = r_out_travel;
    assign o_peak_speed    = r_out_peak;
    assign o_mean_speed    = r_out_mean;
    assign o_peak_pwm      = r_out_pwm;

endmodule

// ----- rtl/msu_serial_div.sv -----
// Restoring divider, one quotient bit per cycle, for the mean speed.
// Depends on msu_pkg.
module msu_serial_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [msu_pkg::SUM_W-1:0]  i_dividend,
    input  logic [msu_pkg::CNT_W-1:0]  i_divisor,
    output msu_pkg::t_div_stat         o_stat,
    output logic [msu_pkg::SUM_W-1:0]  o_quotient
);
    import msu_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_zero, n_zero;
    logic [BIT_W-1:0] r_step, n_step;
    logic [SUM_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_dvs, n_dvs;

    logic [CNT_W:0]   w_shift;
    logic [CNT_W+1:0] w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = !w_diff[CNT_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_zero = r_zero;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_zero = (i_divisor == '0);
            n_step = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo  = {r_quo[SUM_W-2:0], w_ge};
            n_rem  = w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            n_step = r_step + BIT_W'(1);
            if (r_step == BIT_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= n_zero;
        r_step <= n_step;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_stat.done     = r_done;
    assign o_stat.zero_div = r_zero;
    assign o_quotient      = r_quo;

endmodule

// ----- rtl/msu_checker.sv -----
// Port-level checks for the motion move statistics unit, bound to the top level.
// Depends on msu_pkg and motion_move_statistics_unit_assert.svh.
`include "motion_move_statistics_unit_assert.svh"

module msu_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_stall,
    input  logic                             i_move_active,
    input  logic                             o_valid,
    input  logic                             i_stall,
    input  logic [msu_pkg::TIME_W-1:0]       o_elapsed_ms,
    input  logic [msu_pkg::TRAVEL_W-1:0]     o_travel_counts,
    input  logic [msu_pkg::SPEED_W-1:0]      o_peak_speed,
    input  logic [msu_pkg::SPEED_W-1:0]      o_mean_speed,
    input  logic [msu_pkg::PWM_W-1:0]        o_peak_pwm
);
    import msu_pkg::*;

    localparam logic [SPEED_W-1:0] SPEED_TOP = SPEED_W'(SPEED_CLAMP);
    localparam logic [PWM_W-1:0]   PWM_TOP   = PWM_W'(PWM_CLAMP);

    logic [TIME_W+TRAVEL_W+2*SPEED_W+PWM_W-1:0] w_out_bus;

    assign w_out_bus = {o_elapsed_ms, o_travel_counts, o_peak_speed, o_mean_speed, o_peak_pwm};

    `MSU_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    `MSU_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(w_out_bus))
    `MSU_ASSERT_NOW(a_mean_le_peak, o_valid, o_mean_speed <= o_peak_speed && o_peak_speed <= SPEED_TOP)
    `MSU_ASSERT_NOW(a_pwm_clamp, o_valid, o_peak_pwm <= PWM_TOP)
    `MSU_ASSERT_NEXT(a_sample_busy, i_valid && !o_stall && i_move_active, o_stall)

endmodule

bind motion_move_statistics_unit msu_checker u_msu_checker (.*);
